/* design/lpe_pkg.sv */
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants of the L4 payload extractor.
// ----------------------------------------------------------------------------
package lpe_pkg;

	localparam int IDX_W    = 14;
	localparam int ADDR_W   = 32;
	localparam int DATA_W   = 16;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [16:0]      MAX_FRAME    = 17'd16384;
	localparam logic [IDX_W-1:0] IDX_MAX      = 14'h3FFF;
	localparam logic [IDX_W-1:0] ETH_HDR_LEN  = 14'd14;
	localparam logic [IDX_W-1:0] IP_PROTO_IDX = 14'd23;
	localparam logic [IDX_W-1:0] UDP_HDR_LEN  = 14'd8;
	localparam logic [IDX_W-1:0] TCP_OFF_IDX  = 14'd12;
	localparam logic [3:0]       IHL_MIN      = 4'd5;
	localparam logic [3:0]       TCP_OFF_MIN  = 4'd5;
	localparam logic [7:0]       PROTO_TCP    = 8'd6;
	localparam logic [7:0]       PROTO_UDP    = 8'd17;

	// register index, taken from paddr above the byte lanes
	localparam logic REG_BUFFER_CAPACITY = 1'b0;

	typedef struct packed {
		logic [7:0]       in_byte;
		logic             frame_first;
		logic [IDX_W-1:0] frame_length;
	} lpe_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  byte_index;
		logic [IDX_W-1:0]  l4_start;
		logic [IDX_W-1:0]  payload_start;
		logic [7:0]        ip_protocol;
		logic              keep_frame;
		logic [ADDR_W-1:0] write_offset;
		logic [31:0]       packet_count;
	} lpe_state_t;

	typedef struct packed {
		logic [DATA_W-1:0] out_data;
		logic [ADDR_W-1:0] out_addr;
		logic              out_is_prefix;
		logic              out_last;
		logic [31:0]       stored_packets;
		logic [31:0]       stored_bytes;
	} lpe_result_t;

endpackage

/* design/lpe_if.sv */
// ----------------------------------------------------------------------------
// lpe_if
// Valid/ready channels for frame bytes in and buffer writes out.
// ----------------------------------------------------------------------------
interface lpe_item_if;
	import lpe_pkg::*;

	logic             valid;
	logic             ready;
	logic [7:0]       in_byte;
	logic             frame_first;
	logic [IDX_W-1:0] frame_length;

	modport source (output valid, in_byte, frame_first, frame_length, input ready);
	modport sink (input valid, in_byte, frame_first, frame_length, output ready);
endinterface

interface lpe_result_if;
	import lpe_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] out_data;
	logic [ADDR_W-1:0] out_addr;
	logic              out_is_prefix;
	logic              out_last;
	logic [31:0]       stored_packets;
	logic [31:0]       stored_bytes;

	modport source (output valid, out_data, out_addr, out_is_prefix, out_last,
		stored_packets, stored_bytes, input ready);
	modport sink (input valid, out_data, out_addr, out_is_prefix, out_last,
		stored_packets, stored_bytes, output ready);
endinterface

/* design/lpe_step.sv */
// ----------------------------------------------------------------------------
// lpe_step
// Per-beat parse of one frame byte: header tracking, drop checks and the
// buffer write it causes, with the next parser state.
// ----------------------------------------------------------------------------
module lpe_step (
	input  lpe_pkg::lpe_item_t   item,
	input  lpe_pkg::lpe_state_t  state,
	input  logic [31:0]          capacity,
	output lpe_pkg::lpe_state_t  state_next,
	output logic                 res_valid,
	output lpe_pkg::lpe_result_t res
);
	import lpe_pkg::*;

	logic [IDX_W-1:0]  idx;
	logic [IDX_W:0]    idx_inc;
	logic              keep;
	logic [IDX_W-1:0]  l4;
	logic [IDX_W-1:0]  ps;
	logic [7:0]        proto;
	logic [3:0]        ihl;
	logic [3:0]        tcp_off;
	logic [IDX_W-1:0]  pay_len;
	logic [32:0]       rec_end;

	assign ihl     = item.in_byte[3:0];
	assign tcp_off = item.in_byte[7:4];

	always_comb begin
		idx     = item.frame_first ? '0 : state.byte_index;
		idx_inc = {1'b0, idx} + 15'd1;
		keep    = item.frame_first ? ({3'b0, item.frame_length} <= MAX_FRAME)
			: state.keep_frame;
		l4      = item.frame_first ? '0 : state.l4_start;
		ps      = item.frame_first ? '0 : state.payload_start;
		proto   = item.frame_first ? '0 : state.ip_protocol;
		pay_len = item.frame_length - ps;
		rec_end = '0;

		state_next      = state;
		state_next.l4_start      = l4;
		state_next.payload_start = ps;
		state_next.ip_protocol   = proto;
		state_next.byte_index    = (idx < IDX_MAX) ? idx_inc[IDX_W-1:0] : IDX_MAX;

		res_valid = 1'b0;
		res       = '0;

		// header fields
		if (keep) begin
			if (idx == ETH_HDR_LEN) begin
				if (ihl < IHL_MIN) begin
					keep = 1'b0;
				end else begin
					state_next.l4_start = ETH_HDR_LEN + {8'd0, ihl, 2'b00};
				end
			end else if (idx == IP_PROTO_IDX) begin
				state_next.ip_protocol = item.in_byte;
				if (item.in_byte == PROTO_UDP) begin
					state_next.payload_start = l4 + UDP_HDR_LEN;
				end else if (item.in_byte != PROTO_TCP) begin
					keep = 1'b0;
				end
			end else if (proto == PROTO_TCP && l4 != '0 && idx == l4 + TCP_OFF_IDX) begin
				if (tcp_off < TCP_OFF_MIN) begin
					keep = 1'b0;
				end else begin
					state_next.payload_start = l4 + {8'd0, tcp_off, 2'b00};
				end
			end
		end

		ps      = state_next.payload_start;
		pay_len = item.frame_length - ps;
		rec_end = {1'b0, state.write_offset} + 33'd2 + {19'd0, pay_len};

		// record output
		if (keep && ps != '0) begin
			if (idx_inc == {1'b0, ps}) begin
				if (item.frame_length <= ps) begin
					keep = 1'b0;
				end else if (rec_end >= {1'b0, capacity}) begin
					keep = 1'b0;
				end else begin
					res_valid         = 1'b1;
					res.out_data      = {2'b00, pay_len};
					res.out_addr      = state.write_offset;
					res.out_is_prefix = 1'b1;
				end
			end else if (idx >= ps && idx < item.frame_length) begin
				res_valid     = 1'b1;
				res.out_data  = {8'd0, item.in_byte};
				res.out_addr  = state.write_offset + 32'd2 + {18'd0, idx - ps};
				if (idx_inc == {1'b0, item.frame_length}) begin
					res.out_last            = 1'b1;
					state_next.write_offset = rec_end[31:0];
					state_next.packet_count = state.packet_count + 32'd1;
					keep                    = 1'b0;
				end
			end
		end

		state_next.keep_frame = keep;
		res.stored_packets    = state_next.packet_count;
		res.stored_bytes      = state_next.write_offset;
	end
endmodule

/* design/l4_payload_extractor_unit.sv */
// ----------------------------------------------------------------------------
// l4_payload_extractor_unit
// Pulls TCP/UDP payloads out of captured Ethernet/IPv4 frames into a record
// buffer, each record a two-byte length prefix followed by the payload.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock and gives at most one buffer write per byte;
// each byte waits in the input register, and its write is then registered
// in the output register; the only thing that slows the byte rate is
// backpressure on the write side, which holds the output register and then
// the input register. The prefix comes out on the byte just before the
// payload, and stored_packets and stored_bytes advance with the last payload
// byte. buffer_capacity (byte address 0) must be written before any frame is
// kept: at its reset value of zero every frame is dropped.
module l4_payload_extractor_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	lpe_item_if.sink                     frame,
	lpe_result_if.source                 record,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lpe_pkg::PADDR_W-1:0]  paddr,
	input  logic [lpe_pkg::PDATA_W-1:0]  pwdata,
	output logic [lpe_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import lpe_pkg::*;

	lpe_item_t   item_s1;
	logic        valid_s1;
	lpe_state_t  state_q;
	lpe_state_t  state_next;
	logic [31:0] capacity_q;
	lpe_result_t res;
	logic        res_valid;
	lpe_result_t res_q;
	logic        out_valid_q;
	logic        advance;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_BUFFER_CAPACITY) ? capacity_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_BUFFER_CAPACITY) begin
			capacity_q <= pwdata;
		end
	end

	assign advance     = valid_s1 && (!out_valid_q || record.ready);
	assign frame.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			item_s1.in_byte      <= frame.in_byte;
			item_s1.frame_first  <= frame.frame_first;
			item_s1.frame_length <= frame.frame_length;
		end
	end

	lpe_step u_step (
		.item       (item_s1),
		.state      (state_q),
		.capacity   (capacity_q),
		.state_next (state_next),
		.res_valid  (res_valid),
		.res        (res)
	);

	// parser state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_next;
			out_valid_q <= res_valid;
		end else if (record.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign record.valid          = out_valid_q;
	assign record.out_data       = res_q.out_data;
	assign record.out_addr       = res_q.out_addr;
	assign record.out_is_prefix  = res_q.out_is_prefix;
	assign record.out_last       = res_q.out_last;
	assign record.stored_packets = res_q.stored_packets;
	assign record.stored_bytes   = res_q.stored_bytes;
endmodule

/* design/lpe_checker.sv */
// ----------------------------------------------------------------------------
// lpe_checker
// Port-level checks on the extractor's record beats, bound to the top level.
// ----------------------------------------------------------------------------
module lpe_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [lpe_pkg::DATA_W-1:0]   out_data,
	input logic [lpe_pkg::ADDR_W-1:0]   out_addr,
	input logic                         out_is_prefix,
	input logic                         out_last,
	input logic [31:0]                  stored_bytes
);
	import lpe_pkg::*;

	// stalled beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_addr)
			&& $stable(out_is_prefix) && $stable(out_last))
		else $error("record beat changed while stalled");

	// a prefix is always followed by payload, never by another prefix at once
	a_no_double_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_is_prefix |=> !(out_valid && out_is_prefix))
		else $error("two prefix beats in a row");

	// prefix sits at the current write offset
	a_prefix_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_prefix |-> out_addr == stored_bytes && !out_last)
		else $error("prefix address off the write offset");

	// last payload byte ends the record just below the new write offset
	a_last_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_addr + 32'd1 == stored_bytes)
		else $error("last byte address does not close the record");
endmodule

bind l4_payload_extractor_unit lpe_checker u_lpe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (record.valid),
	.out_ready     (record.ready),
	.out_data      (record.out_data),
	.out_addr      (record.out_addr),
	.out_is_prefix (record.out_is_prefix),
	.out_last      (record.out_last),
	.stored_bytes  (record.stored_bytes)
);
